### rtl/cfr_pkg.sv
package cfr_pkg;

  localparam int OPCODE_W = 2;
  localparam int SLOT_W   = 6;
  localparam int PAGE_W   = 20;
  localparam int OWNER_W  = 8;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 7;
  localparam int DATA_W   = PAGE_W + OWNER_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TOUCH = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_PIN   = 2'd3;

  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NO_VICTIM = 2'd1;
  localparam logic [STATUS_W-1:0] STS_BAD_SLOT  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_OP_RD,
    S_OP_EVAL,
    S_FREE_SCAN,
    S_SWEEP,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic valid;
    logic pinned;
    logic accessed;
  } flags_t;

  typedef struct packed {
    logic clear;
    logic idle;
    logic op_rd;
    logic op_eval;
    logic free_scan;
    logic sweep;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic idx_ok;
    logic free_hit;
    logic free_end;
    logic victim;
    logic sweep_end;
    logic out_free;
  } stat_t;

endpackage

### rtl/cfr_ram.sv
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/cfr_ctrl.sv
module cfr_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [cfr_pkg::OPCODE_W-1:0]  in_opcode,
  input  cfr_pkg::stat_t                stat,
  output cfr_pkg::cmd_t                 cmd,
  output logic                          in_stall
);

  import cfr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = (in_opcode == OP_ALLOC) ? S_FREE_SCAN : S_OP_RD;
      end
      S_OP_RD: begin
        state_nxt = stat.idx_ok ? S_OP_EVAL : S_RESULT;
      end
      S_OP_EVAL: begin
        state_nxt = S_RESULT;
      end
      S_FREE_SCAN: begin
        priority if (stat.free_hit) state_nxt = S_RESULT;
        else if (stat.free_end) state_nxt = S_SWEEP;
        else state_nxt = S_FREE_SCAN;
      end
      S_SWEEP: begin
        if (stat.victim || stat.sweep_end) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.clear     = (state_r == S_CLEAR);
    cmd.idle      = (state_r == S_IDLE);
    cmd.op_rd     = (state_r == S_OP_RD);
    cmd.op_eval   = (state_r == S_OP_EVAL);
    cmd.free_scan = (state_r == S_FREE_SCAN);
    cmd.sweep     = (state_r == S_SWEEP);
    cmd.result    = (state_r == S_RESULT);
    in_stall      = (state_r != S_IDLE);
  end

endmodule

### rtl/cfr_dp.sv
module cfr_dp #(
  parameter int FRAME_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfr_pkg::cmd_t                 cmd,
  output cfr_pkg::stat_t                stat,
  input  logic                          in_valid,
  input  logic [cfr_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [cfr_pkg::SLOT_W-1:0]    in_slot_index,
  input  logic [cfr_pkg::PAGE_W-1:0]    in_user_page,
  input  logic [cfr_pkg::OWNER_W-1:0]   in_owner_id,
  input  logic                          in_pin_value,
  input  logic                          cfg_wr_en,
  input  logic [cfr_pkg::LIMIT_W-1:0]   cfg_wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cfr_pkg::STATUS_W-1:0]  out_status,
  output logic [cfr_pkg::SLOT_W-1:0]    out_granted_slot,
  output logic                          out_evicted,
  output logic [cfr_pkg::PAGE_W-1:0]    out_victim_page,
  output logic [cfr_pkg::OWNER_W-1:0]   out_victim_owner
);

  import cfr_pkg::*;

  localparam int AW    = $clog2(FRAME_SLOTS);
  localparam int IW    = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int XW    = (AW > LIMIT_W) ? AW : LIMIT_W;
  localparam int TOTAL = 2 * FRAME_SLOTS + 1;
  localparam int SW    = $clog2(TOTAL + 1);

  localparam logic [AW-1:0] LAST_SLOT = AW'(FRAME_SLOTS - 1);
  localparam logic [SW-1:0] STEP_MAX  = SW'(TOTAL);

  logic [LIMIT_W-1:0]  frame_limit_r;
  logic [LIMIT_W-1:0]  lim;

  logic [OPCODE_W-1:0] req_op_r;
  logic [SLOT_W-1:0]   req_idx_r;
  logic [PAGE_W-1:0]   req_page_r;
  logic [OWNER_W-1:0]  req_owner_r;
  logic                req_pin_r;

  logic [AW-1:0]       hand_r, hand_nxt;
  logic [AW-1:0]       iss_ptr_r, iss_ptr_nxt;
  logic [AW-1:0]       clr_cnt_r;
  logic [LIMIT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic [SW-1:0]       steps_r, steps_nxt;
  logic                rd_pend_r;
  logic [AW-1:0]       rd_addr_q_r;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                res_evicted_r, res_evicted_nxt;
  logic [PAGE_W-1:0]   res_page_r, res_page_nxt;
  logic [OWNER_W-1:0]  res_owner_r, res_owner_nxt;
  logic                res_load;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_evicted_r;
  logic [PAGE_W-1:0]   out_page_r;
  logic [OWNER_W-1:0]  out_owner_r;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                fl_we, dt_we;
  logic [AW-1:0]       wr_addr;
  flags_t              fl_wr, fl_rd;
  logic [DATA_W-1:0]   dt_wr, dt_rd;

  logic [IW-1:0]       idx_ext, pend_ext;
  logic [XW-1:0]       scan_ext;
  logic [AW-1:0]       idx_addr, scan_addr, sweep_base, sweep_addr;
  logic [SLOT_W-1:0]   pend_slot;
  logic                idx_ok, free_hit, free_end, victim, second, sweep_end, out_free;

  flags_t              map_flags;

  cfr_ram #(.WIDTH($bits(flags_t)), .DEPTH(FRAME_SLOTS)) u_flags (
    .clk     (clk),
    .wr_en   (fl_we),
    .wr_addr (wr_addr),
    .wr_data (fl_wr),
    .rd_addr (rd_addr),
    .rd_data (fl_rd)
  );

  cfr_ram #(.WIDTH(DATA_W), .DEPTH(FRAME_SLOTS)) u_data (
    .clk     (clk),
    .wr_en   (dt_we),
    .wr_addr (wr_addr),
    .wr_data (dt_wr),
    .rd_addr (rd_addr),
    .rd_data (dt_rd)
  );

  always_comb begin
    if (32'(frame_limit_r) < FRAME_SLOTS) begin
      lim = frame_limit_r;
    end else begin
      lim = LIMIT_W'(FRAME_SLOTS);
    end
  end

  assign idx_ext    = IW'(req_idx_r);
  assign idx_addr   = idx_ext[AW-1:0];
  assign idx_ok     = 32'(req_idx_r) < FRAME_SLOTS;
  assign scan_ext   = XW'(scan_cnt_r);
  assign scan_addr  = scan_ext[AW-1:0];
  assign pend_ext   = IW'(rd_addr_q_r);
  assign pend_slot  = pend_ext[SLOT_W-1:0];
  assign sweep_base = (steps_r == '0) ? hand_r : iss_ptr_r;
  assign sweep_addr = (sweep_base == LAST_SLOT) ? '0 : sweep_base + 1'b1;

  assign free_hit  = rd_pend_r && !fl_rd.valid;
  assign free_end  = (scan_cnt_r == lim);
  assign victim    = rd_pend_r && fl_rd.valid && !fl_rd.pinned && !fl_rd.accessed;
  assign second    = rd_pend_r && fl_rd.valid && !fl_rd.pinned && fl_rd.accessed;
  assign sweep_end = (steps_r == STEP_MAX);
  assign out_free  = !out_valid_r || !out_stall;

  assign map_flags = '{valid: 1'b1, pinned: 1'b1, accessed: 1'b0};

  always_comb begin
    stat            = '0;
    stat.clear_last = (clr_cnt_r == LAST_SLOT);
    stat.idx_ok     = idx_ok;
    stat.free_hit   = free_hit;
    stat.free_end   = free_end;
    stat.victim     = victim;
    stat.sweep_end  = sweep_end;
    stat.out_free   = out_free;
  end

  always_comb begin
    rd_en           = 1'b0;
    rd_addr         = idx_addr;
    fl_we           = 1'b0;
    dt_we           = 1'b0;
    wr_addr         = rd_addr_q_r;
    fl_wr           = map_flags;
    dt_wr           = {req_page_r, req_owner_r};
    hand_nxt        = hand_r;
    iss_ptr_nxt     = iss_ptr_r;
    scan_cnt_nxt    = scan_cnt_r;
    steps_nxt       = steps_r;
    res_load        = 1'b0;
    res_status_nxt  = STS_OK;
    res_slot_nxt    = req_idx_r;
    res_evicted_nxt = 1'b0;
    res_page_nxt    = '0;
    res_owner_nxt   = '0;

    if (cmd.clear) begin
      fl_we   = 1'b1;
      wr_addr = clr_cnt_r;
      fl_wr   = '0;
    end else if (cmd.idle) begin
      scan_cnt_nxt = '0;
      steps_nxt    = '0;
    end else if (cmd.op_rd) begin
      if (idx_ok) begin
        rd_en   = 1'b1;
        rd_addr = idx_addr;
      end else begin
        res_load       = 1'b1;
        res_status_nxt = STS_BAD_SLOT;
      end
    end else if (cmd.op_eval) begin
      res_load = 1'b1;
      wr_addr  = idx_addr;
      fl_wr    = fl_rd;
      if (!fl_rd.valid) begin
        res_status_nxt = STS_BAD_SLOT;
      end else begin
        fl_we = 1'b1;
        unique case (req_op_r)
          OP_FREE:  fl_wr          = '0;
          OP_TOUCH: fl_wr.accessed = 1'b1;
          OP_PIN:   fl_wr.pinned   = req_pin_r;
          OP_ALLOC: fl_we          = 1'b0;
        endcase
      end
    end else if (cmd.free_scan) begin
      if (free_hit) begin
        fl_we        = 1'b1;
        dt_we        = 1'b1;
        res_load     = 1'b1;
        res_slot_nxt = pend_slot;
      end else if (!free_end) begin
        rd_en        = 1'b1;
        rd_addr      = scan_addr;
        scan_cnt_nxt = scan_cnt_r + 1'b1;
      end
    end else if (cmd.sweep) begin
      if (rd_pend_r) begin
        hand_nxt = rd_addr_q_r;
      end
      priority if (victim) begin
        fl_we           = 1'b1;
        dt_we           = 1'b1;
        res_load        = 1'b1;
        res_slot_nxt    = pend_slot;
        res_evicted_nxt = 1'b1;
        res_page_nxt    = dt_rd[DATA_W-1:OWNER_W];
        res_owner_nxt   = dt_rd[OWNER_W-1:0];
      end else begin
        if (second) begin
          fl_we          = 1'b1;
          fl_wr          = fl_rd;
          fl_wr.accessed = 1'b0;
        end
        if (sweep_end) begin
          res_load       = 1'b1;
          res_status_nxt = STS_NO_VICTIM;
          res_slot_nxt   = '0;
        end else begin
          rd_en       = 1'b1;
          rd_addr     = sweep_addr;
          iss_ptr_nxt = sweep_addr;
          steps_nxt   = steps_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_limit_r <= LIMIT_RESET;
      hand_r        <= LAST_SLOT;
      clr_cnt_r     <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) frame_limit_r <= cfg_wr_data;
      hand_r    <= hand_nxt;
      rd_pend_r <= rd_en;
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.result && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q_r <= rd_addr;
    iss_ptr_r   <= iss_ptr_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    steps_r     <= steps_nxt;
    if (cmd.idle && in_valid) begin
      req_op_r    <= in_opcode;
      req_idx_r   <= in_slot_index;
      req_page_r  <= in_user_page;
      req_owner_r <= in_owner_id;
      req_pin_r   <= in_pin_value;
    end
    if (res_load) begin
      res_status_r  <= res_status_nxt;
      res_slot_r    <= res_slot_nxt;
      res_evicted_r <= res_evicted_nxt;
      res_page_r    <= res_page_nxt;
      res_owner_r   <= res_owner_nxt;
    end
    if (cmd.result && out_free) begin
      out_status_r  <= res_status_r;
      out_slot_r    <= res_slot_r;
      out_evicted_r <= res_evicted_r;
      out_page_r    <= res_page_r;
      out_owner_r   <= res_owner_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_slot = out_slot_r;
  assign out_evicted      = out_evicted_r;
  assign out_victim_page  = out_page_r;
  assign out_victim_owner = out_owner_r;

endmodule

### rtl/clock_frame_replacement.sv
// Free, touch and pin read the slot's flags (S_OP_RD), check and update them (S_OP_EVAL),
// then report (S_RESULT); a slot outside the table goes from S_OP_RD straight to S_RESULT.
// Allocate reads one slot per cycle: a free scan of min(frame_limit, FRAME_SLOTS) slots, then a
// sweep of up to 2*FRAME_SLOTS+1. One request at a time: the controller is back in idle in the
// same cycle that out_valid rises, so the next can be accepted while out_stall holds the result.
// Synchronous reset, then a clearing pass over all FRAME_SLOTS slots with in_stall high.
module clock_frame_replacement #(
  parameter int FRAME_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cfr_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [cfr_pkg::SLOT_W-1:0]    in_slot_index,
  input  logic [cfr_pkg::PAGE_W-1:0]    in_user_page,
  input  logic [cfr_pkg::OWNER_W-1:0]   in_owner_id,
  input  logic                          in_pin_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cfr_pkg::STATUS_W-1:0]  out_status,
  output logic [cfr_pkg::SLOT_W-1:0]    out_granted_slot,
  output logic                          out_evicted,
  output logic [cfr_pkg::PAGE_W-1:0]    out_victim_page,
  output logic [cfr_pkg::OWNER_W-1:0]   out_victim_owner,
  input  logic                          cfg_wr_en,
  input  logic [cfr_pkg::LIMIT_W-1:0]   cfg_wr_data
);

  import cfr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall)
  );

  cfr_dp #(.FRAME_SLOTS(FRAME_SLOTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_opcode        (in_opcode),
    .in_slot_index    (in_slot_index),
    .in_user_page     (in_user_page),
    .in_owner_id      (in_owner_id),
    .in_pin_value     (in_pin_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_granted_slot (out_granted_slot),
    .out_evicted      (out_evicted),
    .out_victim_page  (out_victim_page),
    .out_victim_owner (out_victim_owner)
  );

`ifndef NO_ASSERTIONS
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in progress");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result && stat.out_free |=> out_valid && cmd.idle)
    else $error("finished result not moved to the output");

  a_rise_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.result))
    else $error("output raised without a finished request");

  a_no_victim_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_NO_VICTIM |-> !out_evicted && out_granted_slot == '0)
    else $error("failed allocate reports a slot");
`endif

endmodule

### test/tb_clock_frame_replacement.sv
`timescale 1ns / 1ps

module tb_clock_frame_replacement;
  import cfr_pkg::*;

  localparam int SLOTS = 64;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [SLOT_W-1:0]   slot;
    logic [PAGE_W-1:0]   page;
    logic [OWNER_W-1:0]  owner;
    logic                pin;
  } frame_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [PAGE_W-1:0]   page;
    logic [OWNER_W-1:0]  owner;
  } frame_resp_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OPCODE_W-1:0] in_opcode;
  logic [SLOT_W-1:0]   in_slot_index;
  logic [PAGE_W-1:0]   in_user_page;
  logic [OWNER_W-1:0]  in_owner_id;
  logic                in_pin_value;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_granted_slot;
  logic                out_evicted;
  logic [PAGE_W-1:0]   out_victim_page;
  logic [OWNER_W-1:0]  out_victim_owner;
  logic                cfg_wr_en;
  logic [LIMIT_W-1:0]  cfg_wr_data;

  logic                frame_valid    [SLOTS];
  logic                frame_pinned   [SLOTS];
  logic                frame_accessed [SLOTS];
  logic [PAGE_W-1:0]   frame_vpage    [SLOTS];
  logic [OWNER_W-1:0]  frame_owner    [SLOTS];
  int                  sweep_hand;
  logic [LIMIT_W-1:0]  limit_shadow;

  frame_resp_t         expected_q[$];
  int                  mismatch_count = 0;
  bit                  gap_on = 1'b1;
  bit                  stall_on = 1'b1;
  bit                  tx_holding = 1'b0;
  int                  hold_req = 0;

  clock_frame_replacement #(.FRAME_SLOTS(SLOTS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_slot_index    (in_slot_index),
    .in_user_page     (in_user_page),
    .in_owner_id      (in_owner_id),
    .in_pin_value     (in_pin_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_granted_slot (out_granted_slot),
    .out_evicted      (out_evicted),
    .out_victim_page  (out_victim_page),
    .out_victim_owner (out_victim_owner),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_frames();
    for (int s = 0; s < SLOTS; s++) begin
      frame_valid[s] = 1'b0;
      frame_pinned[s] = 1'b0;
      frame_accessed[s] = 1'b0;
      frame_vpage[s] = '0;
      frame_owner[s] = '0;
    end
    sweep_hand = SLOTS - 1;
    limit_shadow = LIMIT_RESET;
  endfunction

  function automatic void map_frame(int s, frame_req_t r);
    frame_valid[s] = 1'b1;
    frame_pinned[s] = 1'b1;
    frame_accessed[s] = 1'b0;
    frame_vpage[s] = r.page;
    frame_owner[s] = r.owner;
  endfunction

  function automatic frame_resp_t apply_request(frame_req_t r);
    frame_resp_t rsp;
    int lim;
    int s;
    rsp = '0;
    rsp.slot = r.slot;
    if (r.opcode == OP_ALLOC) begin
      lim = (limit_shadow > SLOTS) ? SLOTS : int'(limit_shadow);
      for (s = 0; s < lim; s++) begin
        if (!frame_valid[s]) begin
          map_frame(s, r);
          rsp.slot = SLOT_W'(s);
          return rsp;
        end
      end
      for (int step = 0; step < 2 * SLOTS + 1; step++) begin
        sweep_hand = (sweep_hand + 1) % SLOTS;
        s = sweep_hand;
        if (!frame_valid[s] || frame_pinned[s]) continue;
        if (frame_accessed[s]) begin
          frame_accessed[s] = 1'b0;
          continue;
        end
        rsp.slot = SLOT_W'(s);
        rsp.evicted = 1'b1;
        rsp.page = frame_vpage[s];
        rsp.owner = frame_owner[s];
        map_frame(s, r);
        return rsp;
      end
      rsp.status = STS_NO_VICTIM;
      rsp.slot = '0;
      return rsp;
    end
    if (r.slot >= SLOTS || !frame_valid[r.slot]) begin
      rsp.status = STS_BAD_SLOT;
      return rsp;
    end
    case (r.opcode)
      OP_FREE: begin
        frame_valid[r.slot] = 1'b0;
        frame_pinned[r.slot] = 1'b0;
        frame_accessed[r.slot] = 1'b0;
      end
      OP_TOUCH: frame_accessed[r.slot] = 1'b1;
      default: frame_pinned[r.slot] = r.pin;
    endcase
    return rsp;
  endfunction

  function automatic frame_req_t make_request(logic [OPCODE_W-1:0] op, int slot,
                                              int page, int owner, bit pin);
    frame_req_t r;
    r.opcode = op;
    r.slot = SLOT_W'(slot);
    r.page = PAGE_W'(page);
    r.owner = OWNER_W'(owner);
    r.pin = pin;
    return r;
  endfunction

  function automatic frame_req_t random_request();
    frame_req_t r;
    int live[$];
    int pick;
    for (int s = 0; s < SLOTS; s++)
      if (frame_valid[s]) live.push_back(s);
    pick = $urandom_range(0, 99);
    r.opcode = (pick < 35) ? OP_ALLOC : (pick < 57) ? OP_PIN : (pick < 78) ? OP_TOUCH : OP_FREE;
    if (live.size() > 0 && $urandom_range(0, 9) < 8)
      r.slot = SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
    else
      r.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
    r.page = PAGE_W'($urandom());
    r.owner = OWNER_W'($urandom());
    r.pin = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  task automatic send_request(frame_req_t r);
    int gap;
    gap = gap_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      if (tx_holding) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_opcode <= r.opcode;
    in_slot_index <= r.slot;
    in_user_page <= r.page;
    in_owner_id <= r.owner;
    in_pin_value <= r.pin;
    in_valid <= 1'b1;
    tx_holding = 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    expected_q.push_back(apply_request(r));
  endtask

  task automatic wait_for_results();
    if (tx_holding) in_valid <= 1'b0;
    tx_holding = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_frame_limit(logic [LIMIT_W-1:0] value);
    wait_for_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_shadow = value;
  endtask

  task automatic send_random(int count);
    repeat (count) send_request(random_request());
  endtask

  task automatic test_directed_cases();
    send_request(make_request(OP_FREE, 63, 0, 0, 1'b0));
    send_request(make_request(OP_TOUCH, 0, 0, 0, 1'b0));
    send_request(make_request(OP_PIN, 5, 0, 0, 1'b1));
    send_request(make_request(OP_ALLOC, 0, 0, 0, 1'b0));
    send_request(make_request(OP_ALLOC, 63, 'hFFFFF, 'hFF, 1'b1));
    send_request(make_request(OP_ALLOC, 0, 'hABCDE, 'h5A, 1'b0));
    send_request(make_request(OP_TOUCH, 0, 0, 0, 1'b0));
    send_request(make_request(OP_PIN, 0, 0, 0, 1'b0));
    send_request(make_request(OP_PIN, 1, 0, 0, 1'b0));
    send_request(make_request(OP_PIN, 2, 0, 0, 1'b1));
    send_request(make_request(OP_FREE, 2, 0, 0, 1'b0));
    send_request(make_request(OP_FREE, 2, 0, 0, 1'b0));
    set_frame_limit(7'd0);
    send_request(make_request(OP_ALLOC, 0, 'h12345, 'h01, 1'b0));
    send_request(make_request(OP_ALLOC, 0, 'h54321, 'h02, 1'b0));
    send_request(make_request(OP_ALLOC, 0, 'h0F0F0, 'h03, 1'b0));
    send_request(make_request(OP_PIN, 0, 0, 0, 1'b0));
    send_request(make_request(OP_TOUCH, 0, 0, 0, 1'b0));
    send_request(make_request(OP_ALLOC, 0, 'hF0F0F, 'h04, 1'b0));
    set_frame_limit(7'd127);
    send_request(make_request(OP_ALLOC, 0, 'h00001, 'h80, 1'b0));
    send_request(make_request(OP_PIN, 63, 0, 0, 1'b0));
    set_frame_limit(7'd1);
    send_request(make_request(OP_PIN, 2, 0, 0, 1'b0));
    send_request(make_request(OP_ALLOC, 0, 'h80000, 'h7F, 1'b0));
    send_request(make_request(OP_TOUCH, 63, 0, 0, 1'b0));
  endtask

  task automatic test_limit_settings();
    logic [LIMIT_W-1:0] limits[8];
    limits = '{7'd64, 7'd1, 7'd4, 7'd0, 7'd127, 7'd2, LIMIT_W'($urandom_range(1, 64)), 7'd16};
    for (int p = 0; p < 8; p++) begin
      set_frame_limit(limits[p]);
      gap_on = (p % 3) != 1;
      stall_on = (p % 3) != 2;
      send_random(110);
    end
    gap_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_full_backpressure();
    set_frame_limit(7'd8);
    hold_req = 400;
    gap_on = 1'b0;
    send_random(40);
    wait_for_results();
    gap_on = 1'b1;
    send_random(40);
  endtask

  task automatic test_mixed_traffic();
    for (int p = 0; p < 5; p++) begin
      if (p == 2) set_frame_limit(LIMIT_W'($urandom_range(1, 64)));
      gap_on = p != 3;
      stall_on = p != 1;
      send_random(140);
    end
    gap_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin : out_side
    int hold;
    out_stall <= 1'b0;
    forever begin
      hold = hold_req + (stall_on ? $urandom_range(0, 7) : 0);
      hold_req = 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      forever begin
        @(posedge clk);
        if (out_valid && !out_stall) break;
        if (hold_req > 0) break;
      end
    end
  end

  always @(posedge clk) begin : result_check
    frame_resp_t got;
    frame_resp_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_granted_slot, out_evicted, out_victim_page, out_victim_owner};
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result st=%0d slot=%0d ev=%0d page=%h owner=%h",
                   got.status, got.slot, got.evicted, got.page, got.owner);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("mismatch: expected st=%0d slot=%0d ev=%0d page=%h owner=%h, ",
                   want.status, want.slot, want.evicted, want.page, want.owner);
            $display("got st=%0d slot=%0d ev=%0d page=%h owner=%h",
                     got.status, got.slot, got.evicted, got.page, got.owner);
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb_clock_frame_replacement: done, errors");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= OP_ALLOC;
    in_slot_index <= '0;
    in_user_page <= '0;
    in_owner_id <= '0;
    in_pin_value <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    clear_frames();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    test_directed_cases();
    test_limit_settings();
    test_full_backpressure();
    test_mixed_traffic();
    wait_for_results();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_clock_frame_replacement: done, clean");
    else
      $display("tb_clock_frame_replacement: done, errors");
    $finish;
  end

endmodule

### files.f
rtl/cfr_pkg.sv
rtl/cfr_ram.sv
rtl/cfr_ctrl.sv
rtl/cfr_dp.sv
rtl/clock_frame_replacement.sv
test/tb_clock_frame_replacement.sv
